[src/sbpra_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbpra_pkg: shared constants and types
// Sizes of the section bitmap and run table, and the status codes.
// ----------------------------------------------------------------------------
package sbpra_pkg;

    localparam int MAP_WORDS   = 32;
    localparam int RUN_ENTRIES = 16;
    localparam int MAP_AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int RUN_AW      = (RUN_ENTRIES > 1) ? $clog2(RUN_ENTRIES) : 1;
    localparam int PAGE_W      = 18;
    localparam int COUNT_W     = 19;
    localparam int SEC_W       = MAP_AW + 5;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    typedef struct packed {
        logic             start;
        logic [4:0]       need;
    } scan_req_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [SEC_W-1:0] section;
    } scan_rsp_t;

endpackage
`default_nettype wire

[src/sbpra_map.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbpra_map: section free bitmap
// Memory of bitmap words with a word-serial scan for a run of free sections
// and a set pass for freed sections that sets one section at a time.
// ----------------------------------------------------------------------------
module sbpra_map
    import sbpra_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scan_req_t         scan_req,
    output scan_rsp_t              scan_rsp,
    input  wire logic              set_en,
    input  wire logic [SEC_W-1:0]  set_first,
    input  wire logic [SEC_W:0]    set_count
);

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_READ  = 3'd1;
    localparam logic [2:0] M_BIT   = 3'd2;
    localparam logic [2:0] M_SET   = 3'd3;
    localparam logic [2:0] M_CLEAR = 3'd4;

    logic [31:0]       mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] written_reg;

    logic [2:0]        state_reg, state_next;
    logic [MAP_AW:0]   word_reg, word_next;
    logic [4:0]        bit_reg, bit_next;
    logic [4:0]        start_reg, start_next;
    logic [5:0]        len_reg, len_next;
    logic [4:0]        need_reg, need_next;
    logic [31:0]       data_reg;
    logic [SEC_W:0]    sec_reg, sec_next;
    logic [SEC_W:0]    left_reg, left_next;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic [SEC_W-1:0]  res_reg, res_next;
    logic [MAP_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MAP_AW-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic [31:0]       clr_mask;
    logic [31:0]       rd_word;
    logic              cur_bit;

    assign rd_word = data_reg;
    assign cur_bit = rd_word[5'd31 - bit_reg];

    // mask of bits start..start+need-1 counted from the msb
    always_comb
    begin
        clr_mask = '0;
        for (int k = 0; k < 32; k++)
        begin
            if (k >= int'(start_reg) && k < int'(start_reg) + int'(need_reg))
                clr_mask[31-k] = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        bit_next   = bit_reg;
        start_next = start_reg;
        len_next   = len_reg;
        need_next  = need_reg;
        sec_next   = sec_reg;
        left_next  = left_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        res_next   = res_reg;
        rd_addr    = word_reg[MAP_AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = word_reg[MAP_AW-1:0];
        wr_data    = rd_word;
        case (state_reg)
            M_IDLE:
            begin
                if (scan_req.start)
                begin
                    need_next  = scan_req.need;
                    word_next  = '0;
                    rd_addr    = '0;
                    state_next = M_READ;
                end
                else if (set_en && set_count != '0)
                begin
                    sec_next   = {1'b0, set_first};
                    left_next  = set_count;
                    rd_addr    = set_first[SEC_W-1:5];
                    state_next = M_SET;
                end
            end
            M_READ:
            begin
                bit_next   = '0;
                len_next   = '0;
                state_next = M_BIT;
            end
            M_BIT:
            begin
                if (cur_bit)
                begin
                    if (len_reg == 6'd0)
                        start_next = bit_reg;
                    len_next = len_reg + 6'd1;
                    if (len_reg + 6'd1 >= {1'b0, need_reg})
                    begin
                        if (len_reg == 6'd0)
                            start_next = bit_reg;
                        state_next = M_CLEAR;
                    end
                end
                else
                    len_next = '0;
                if (state_next == M_BIT)
                begin
                    bit_next = bit_reg + 5'd1;
                    if (bit_reg == 5'd31)
                    begin
                        if (word_reg == (MAP_AW+1)'(MAP_WORDS - 1))
                        begin
                            done_next  = 1'b1;
                            found_next = 1'b0;
                            state_next = M_IDLE;
                        end
                        else
                        begin
                            word_next  = word_reg + 1'b1;
                            rd_addr    = MAP_AW'(word_reg + 1'b1);
                            state_next = M_READ;
                        end
                    end
                end
            end
            M_CLEAR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_word & ~clr_mask;
                done_next  = 1'b1;
                found_next = 1'b1;
                res_next   = SEC_W'({word_reg[MAP_AW-1:0], start_reg});
                state_next = M_IDLE;
            end
            M_SET:
            begin
                // one section per cycle; data_reg holds the current word
                wr_en     = 1'b1;
                wr_addr   = sec_reg[SEC_W-1:5];
                wr_data   = rd_word | (32'h8000_0000 >> sec_reg[4:0]);
                sec_next  = sec_reg + 1'b1;
                left_next = left_reg - 1'b1;
                rd_addr   = sec_next[SEC_W-1:5];
                if (left_reg == (SEC_W+1)'(1))
                    state_next = M_IDLE;
            end
            default:
                state_next = M_IDLE;
        endcase
    end

    // read data is registered; during a set pass the just-written word is
    // forwarded so consecutive sections of one word accumulate
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (wr_en && wr_addr == rd_addr)
            data_reg <= wr_data;
        else if (written_reg[rd_addr])
            data_reg <= mem[rd_addr];
        else
            data_reg <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= M_IDLE;
            done_reg    <= 1'b0;
            written_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (wr_en)
                written_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        bit_reg   <= bit_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        need_reg  <= need_next;
        sec_reg   <= sec_next;
        left_reg  <= left_next;
        found_reg <= found_next;
        res_reg   <= res_next;
    end

    assign scan_rsp.done    = done_reg;
    assign scan_rsp.found   = found_reg;
    assign scan_rsp.section = res_reg;

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("scan done held");
    a_clear_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == M_CLEAR |=> done_reg && found_reg) else $error("clear w/o found");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        scan_req.start |-> state_reg == M_IDLE) else $error("scan start while busy");
`endif

endmodule
`default_nettype wire

[src/section_bitmap_page_run_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// section_bitmap_page_run_allocator: physical page allocator
// Claims and frees pages over 256-page sections, with a free-section
// bitmap and a small table of partial runs.
// ----------------------------------------------------------------------------
// One request at a time. A free, or a claim of under 256 pages, first walks
// the run table one entry per cycle (a free walks it up to twice more to
// place its head and tail pieces). Section work adds a bitmap scan that tests
// one bit per cycle, word by word, or a set pass of one section per cycle.
// s_tready is low while a request is in work; the result waits in an output
// register. After reset the bitmap reads all allocated and the table is
// empty; no clearing pass is needed.
module section_bitmap_page_run_allocator
    import sbpra_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // cmd, free_base[17:0], page_count[18:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // page_base[17:0], status[1:0]
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_COUNT  = 4'd2;
    localparam logic [3:0] S_FREEH  = 4'd3;
    localparam logic [3:0] S_FREEM  = 4'd4;
    localparam logic [3:0] S_FREET  = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_SCAN   = 4'd7;
    localparam logic [3:0] S_WAITS  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;
    localparam logic [3:0] S_WAITM  = 4'd10;

    localparam logic [COUNT_W:0] TOTAL = (COUNT_W+1)'(MAP_WORDS * 32 * 256);

    logic [3:0]          state_reg, state_next;
    logic                cmd_reg;
    logic [PAGE_W-1:0]   base_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [8:0]          head_reg, head_next;
    logic [8:0]          tail_reg, tail_next;
    logic [COUNT_W-1:0]  mid_reg, mid_next;
    logic [RUN_AW:0]     idx_reg, idx_next;
    logic [RUN_AW:0]     empty_reg, empty_next;
    logic                have_e_reg, have_e_next;
    logic [RUN_AW-1:0]   e_idx_reg, e_idx_next;
    logic                partial_reg, partial_next;
    logic [PAGE_W-1:0]   pb_reg, pb_next;
    logic [1:0]          st_reg, st_next;
    logic                ov_reg, ov_next;

    logic [8:0]          cnt_mem [RUN_ENTRIES];
    logic [PAGE_W-1:0]   start_mem [RUN_ENTRIES];
    logic [RUN_ENTRIES-1:0] tvalid_reg;
    logic [RUN_AW-1:0]   ridx;
    logic [8:0]          rcnt;
    logic [PAGE_W-1:0]   rstart;
    logic                twr;
    logic [RUN_AW-1:0]   twr_idx;
    logic [8:0]          twr_cnt;
    logic [PAGE_W-1:0]   twr_start;
    logic                put_h;
    logic [COUNT_W:0]    end_page;
    logic [7:0]          off;
    logic [8:0]          hcalc;
    logic [COUNT_W-1:0]  rest;
    logic [RUN_AW:0]     need_ent;
    logic [RUN_AW:0]     empty_tot;

    scan_req_t           scan_req;
    scan_rsp_t           scan_rsp;
    logic                set_en;
    logic [SEC_W-1:0]    set_first;
    logic [SEC_W:0]      set_count;

    sbpra_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_req (scan_req),
        .scan_rsp (scan_rsp),
        .set_en   (set_en),
        .set_first(set_first),
        .set_count(set_count)
    );

    // table counts read as empty until an entry is first written
    assign ridx   = idx_reg[RUN_AW-1:0];
    assign rcnt   = tvalid_reg[ridx] ? cnt_mem[ridx] : 9'd0;
    assign rstart = start_mem[ridx];
    assign end_page = {1'b0, base_reg} + {1'b0, cnt_reg};
    assign off    = base_reg[7:0];
    assign hcalc  = (off == 8'd0) ? 9'd0
                  : ((9'h100 - {1'b0, off}) > 9'(cnt_reg) && cnt_reg < 19'd256)
                    ? 9'(cnt_reg) : (9'h100 - {1'b0, off});
    assign rest   = cnt_reg - COUNT_W'(hcalc);
    assign need_ent  = {{RUN_AW{1'b0}}, head_reg != 9'd0}
                     + {{RUN_AW{1'b0}}, tail_reg != 9'd0};
    assign empty_tot = empty_reg + {{RUN_AW{1'b0}}, rcnt == 9'd0};

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        mid_next     = mid_reg;
        idx_next     = idx_reg;
        empty_next   = empty_reg;
        have_e_next  = have_e_reg;
        e_idx_next   = e_idx_reg;
        partial_next = partial_reg;
        pb_next      = pb_reg;
        st_next      = st_reg;
        ov_next      = ov_reg;
        twr          = 1'b0;
        twr_idx      = ridx;
        twr_cnt      = rcnt;
        twr_start    = rstart;
        put_h        = 1'b0;
        scan_req     = '0;
        set_en       = 1'b0;
        set_first    = SEC_W'((base_reg + PAGE_W'(head_reg)) >> 8);
        set_count    = (SEC_W+1)'(mid_reg >> 8);
        case (state_reg)
            S_IDLE: ;
            S_CHECK:
            begin
                pb_next = '0;
                idx_next = '0;
                empty_next = '0;
                have_e_next = 1'b0;
                if (cmd_reg)
                begin
                    head_next = hcalc;
                    mid_next  = rest & ~COUNT_W'(8'hff);
                    tail_next = {1'b0, rest[7:0]};
                    if (end_page > TOTAL)
                    begin
                        st_next = ST_ERROR;
                        state_next = S_OUT;
                    end
                    else if (cnt_reg == '0)
                    begin
                        st_next = ST_DONE;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_COUNT;
                end
                else if (cnt_reg == '0)
                begin
                    st_next = ST_ERROR;
                    state_next = S_OUT;
                end
                else if (cnt_reg[7:0] == 8'd0)
                begin
                    if (cnt_reg[COUNT_W-1:8] >= 11'd32)
                    begin
                        st_next = ST_ERROR;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        partial_next = 1'b0;
                        scan_req.start = 1'b1;
                        scan_req.need  = cnt_reg[12:8];
                        state_next = S_WAITS;
                    end
                end
                else if (cnt_reg >= 19'h100)
                begin
                    st_next = ST_ERROR;
                    state_next = S_OUT;
                end
                else
                begin
                    partial_next = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_COUNT:
            begin
                if (rcnt == 9'd0)
                    empty_next = empty_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (RUN_AW+1)'(RUN_ENTRIES - 1))
                begin
                    idx_next = '0;
                    if (need_ent > empty_tot)
                    begin
                        st_next = ST_ERROR;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        st_next = ST_DONE;
                        state_next = (head_reg != 9'd0) ? S_FREEH : S_FREEM;
                    end
                end
            end
            S_FREEH, S_FREET:
            begin
                // lowest empty entry
                if (rcnt == 9'd0)
                begin
                    twr = 1'b1;
                    put_h = (state_reg == S_FREEH);
                    twr_cnt = put_h ? head_reg : tail_reg;
                    // tail piece ends where the freed range ends
                    twr_start = put_h ? base_reg
                              : PAGE_W'(end_page - {{(COUNT_W-8){1'b0}}, tail_reg});
                    idx_next = '0;
                    state_next = put_h ? S_FREEM : S_OUT;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_FREEM:
            begin
                set_en = (mid_reg != '0);
                state_next = (tail_reg != 9'd0) ? S_FREET : S_OUT;
                if (mid_reg != '0)
                    state_next = S_WAITM;
            end
            S_WAITM:
            begin
                // set pass runs one section per cycle; count down here
                mid_next = mid_reg - COUNT_W'(9'h100);
                if (mid_reg == COUNT_W'(9'h100))
                    state_next = (tail_reg != 9'd0) ? S_FREET : S_OUT;
            end
            S_WALK:
            begin
                if (rcnt >= 9'(cnt_reg))
                begin
                    twr = 1'b1;
                    twr_cnt = rcnt - 9'(cnt_reg);
                    twr_start = rstart + PAGE_W'(cnt_reg);
                    pb_next = rstart;
                    st_next = ST_DONE;
                    state_next = S_OUT;
                end
                else
                begin
                    if (rcnt == 9'd0)
                    begin
                        have_e_next = 1'b1;
                        e_idx_next = ridx;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == (RUN_AW+1)'(RUN_ENTRIES - 1))
                    begin
                        if (!have_e_next)
                        begin
                            st_next = ST_NOSPACE;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            scan_req.start = 1'b1;
                            scan_req.need  = 5'd1;
                            state_next = S_WAITS;
                        end
                    end
                end
            end
            S_WAITS:
            begin
                if (scan_rsp.done)
                begin
                    if (!scan_rsp.found)
                        st_next = ST_NOSPACE;
                    else
                    begin
                        st_next = ST_DONE;
                        pb_next = PAGE_W'({scan_rsp.section, 8'h00});
                        if (partial_reg)
                        begin
                            twr = 1'b1;
                            twr_idx = e_idx_reg;
                            twr_cnt = 9'h100 - 9'(cnt_reg);
                            twr_start = PAGE_W'({scan_rsp.section, 8'h00}) + PAGE_W'(cnt_reg);
                        end
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (st_next != ST_DONE || cmd_reg)
                    pb_next = (st_next == ST_DONE) ? pb_reg : '0;
                if (cmd_reg)
                    pb_next = '0;
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (ov_reg && m_tready)
            ov_next = (state_reg == S_OUT);
    end

    always_ff @(posedge clk)
    begin
        if (twr)
        begin
            cnt_mem[twr_idx]   <= twr_cnt;
            start_mem[twr_idx] <= twr_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ov_reg     <= 1'b0;
            tvalid_reg <= '0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (twr)
                tvalid_reg[twr_idx] <= 1'b1;
            if (state_reg == S_IDLE && s_tvalid && s_tready)
                state_reg <= S_CHECK;
            else
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid && s_tready)
        begin
            cmd_reg  <= s_tdata[0];
            base_reg <= s_tdata[18:1];
            cnt_reg  <= s_tdata[37:19];
        end
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        mid_reg     <= mid_next;
        idx_reg     <= idx_next;
        empty_reg   <= empty_next;
        have_e_reg  <= have_e_next;
        e_idx_reg   <= e_idx_next;
        partial_reg <= partial_next;
        pb_reg      <= pb_next;
        st_reg      <= st_next;
    end

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, st_reg, pb_reg};

`ifndef NO_ASSERTIONS
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> st_reg != 2'd3) else $error("bad status");
    a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && st_reg != ST_DONE |-> pb_reg == '0) else $error("base on failure");
`endif

endmodule
`default_nettype wire
